### rtl/csvt_pkg.sv
`timescale 1ns / 1ps
// Package for the CSV field tokenizer: widths, position limit, parser modes,
// character codes, the result record and the saturating adder.
// Depends on nothing; imported by csv_field_tokenizer.
package csvt_pkg;

  // Offsets and lengths are reported in 16 bits.
  localparam int unsigned POS_W = 16;

  // Largest buffer the block is sized for; positions saturate at LIMIT.
  localparam longint unsigned MAX_BYTES = 65535;
  localparam longint unsigned POS_MAX   = (64'd1 << POS_W) - 64'd1;
  localparam logic [POS_W:0]  LIMIT     =
      (POS_W + 1)'((MAX_BYTES < POS_MAX) ? MAX_BYTES : POS_MAX);

  // Result queue depth; an item may push two results.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Characters that steer the parser.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Parser mode; the unused codes behave as field start.
  typedef enum logic [2:0] {
    M_START  = 3'd0,
    M_PLAIN  = 3'd1,
    M_QUOTED = 3'd2,
    M_QSEEN  = 3'd3,
    M_CR     = 3'd4
  } mode_e;

  // One field report as it sits in the result queue.
  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic [POS_W-1:0] next;
    logic             last;
    logic             ovf;
  } result_t;

  // Adds a small increment and saturates at LIMIT.
  function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] v, logic [1:0] k);
    logic [POS_W:0] sum;
    sum = {1'b0, v} + {{(POS_W - 1){1'b0}}, k};
    if (sum > LIMIT) begin
      return LIMIT[POS_W-1:0];
    end
    return sum[POS_W-1:0];
  endfunction

endpackage

### rtl/csv_field_tokenizer.sv
`timescale 1ns / 1ps
// CSV field tokenizer top level: byte parser, mode register and result queue.
// Depends on csvt_pkg.
//
// The block takes one CSV text byte per transfer and reports each field as
// its start offset, raw length and the offset where the next field begins.
// The parser is combinational from the mode and position registers, so a
// byte can be accepted every cycle while the queue has room. Each byte yields
// zero, one or two results, which go into a four-entry result queue; the
// output side drains one result per cycle while out_ready_i is high. Input is
// accepted while the queue has room for two results, so the sustained rate is
// one byte per cycle as long as bytes average at most one result and the
// output is ready, and otherwise the output port sets the pace at one result
// per cycle. A byte flagged end_of_data closes the buffer and the next byte starts again at offset zero.
module csv_field_tokenizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [csvt_pkg::POS_W-1:0] field_start_o,
  output logic [csvt_pkg::POS_W-1:0] field_length_o,
  output logic [csvt_pkg::POS_W-1:0] next_offset_o,
  output logic                      run_last_o,
  output logic                      overflow_o
);
  import csvt_pkg::*;

  // Parser state.
  mode_e            mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] fstart_q, fstart_d;
  logic [POS_W-1:0] flen_q, flen_d;
  logic             ovf_q, ovf_d;

  // Result queue.
  result_t           queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic             in_fire, out_fire;
  logic [POS_W-1:0] pos_inc;
  logic             ovf_now;
  logic             is_sep, is_cr, is_quote, is_lf;
  mode_e            mode_step;

  // Field reports of this byte, in emission order.
  logic             ea_v, eb_v, ec_v;
  logic [POS_W-1:0] ea_next;
  result_t          res0, res1;
  logic [1:0]       n_res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (cnt_q <= QCNT_W'(QDEPTH - 2));

  assign pos_inc  = sat_add(pos_q, 2'd1);
  assign ovf_now  = ovf_q || ({1'b0, pos_q} >= LIMIT);
  assign is_sep   = (data_byte_i == CH_COMMA) || (data_byte_i == CH_LF);
  assign is_cr    = (data_byte_i == CH_CR);
  assign is_quote = (data_byte_i == CH_QUOTE);
  assign is_lf    = (data_byte_i == CH_LF);

  // Next parser state for the current byte.
  always_comb begin
    mode_step = mode_q;
    fstart_d  = fstart_q;
    flen_d    = flen_q;
    case (mode_q)
      M_PLAIN: begin
        if (is_sep) begin
          mode_step = M_START;
        end else if (is_cr) begin
          mode_step = M_CR;
        end else begin
          flen_d = sat_add(flen_q, 2'd1);
        end
      end
      M_QUOTED: begin
        if (is_quote) begin
          mode_step = M_QSEEN;
        end else begin
          flen_d = sat_add(flen_q, 2'd1);
        end
      end
      M_QSEEN: begin
        if (is_quote) begin
          mode_step = M_QUOTED;
          flen_d    = sat_add(flen_q, 2'd2);
        end else if (is_sep) begin
          mode_step = M_START;
        end else if (is_cr) begin
          mode_step = M_CR;
        end else begin
          // Data right after a closing quote opens a plain field.
          mode_step = M_PLAIN;
          fstart_d  = pos_q;
          flen_d    = {{(POS_W - 1){1'b0}}, 1'b1};
        end
      end
      default: begin
        // Field start, also after a CR that is not followed by LF.
        if ((mode_q == M_CR) && is_lf) begin
          mode_step = M_START;
        end else if (is_sep) begin
          mode_step = M_START;
        end else if (is_cr) begin
          mode_step = M_CR;
          fstart_d  = pos_q;
          flen_d    = '0;
        end else if (is_quote) begin
          mode_step = M_QUOTED;
          fstart_d  = pos_inc;
          flen_d    = '0;
        end else begin
          mode_step = M_PLAIN;
          fstart_d  = pos_q;
          flen_d    = {{(POS_W - 1){1'b0}}, 1'b1};
        end
      end
    endcase
  end

  // End of data returns the parser state to its reset values.
  always_comb begin
    if (end_of_data_i) begin
      mode_d = M_START;
      pos_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      mode_d = mode_step;
      pos_d  = pos_inc;
      ovf_d  = ovf_now;
    end
  end

  // Field reports: the open field closing, an empty field, and the final flush.
  always_comb begin
    ea_v    = 1'b0;
    eb_v    = 1'b0;
    ea_next = pos_inc;
    case (mode_q)
      M_PLAIN: begin
        ea_v = is_sep;
      end
      M_QSEEN: begin
        ea_v    = !is_quote && !is_cr;
        ea_next = is_sep ? pos_inc : pos_q;
      end
      M_CR: begin
        ea_v    = 1'b1;
        ea_next = is_lf ? pos_inc : pos_q;
        eb_v    = !is_lf && is_sep;
      end
      M_QUOTED: begin
        ea_v = 1'b0;
      end
      default: begin
        eb_v = is_sep;
      end
    endcase
    ec_v = end_of_data_i && (mode_step != M_START);

    n_res = {1'b0, ea_v} + {1'b0, eb_v} + {1'b0, ec_v};

    // First result slot.
    if (ea_v) begin
      res0 = '{start: fstart_q, length: flen_q, next: ea_next,
               last: 1'b0, ovf: ovf_now};
    end else if (eb_v) begin
      res0 = '{start: pos_q, length: '0, next: pos_inc, last: 1'b0, ovf: ovf_now};
    end else begin
      res0 = '{start: fstart_d, length: flen_d, next: pos_inc,
               last: 1'b0, ovf: ovf_now};
    end
    // Second result slot, used only when two reports are issued.
    if (eb_v) begin
      res1 = '{start: pos_q, length: '0, next: pos_inc, last: 1'b1, ovf: ovf_now};
    end else begin
      res1 = '{start: fstart_d, length: flen_d, next: pos_inc,
               last: 1'b1, ovf: ovf_now};
    end
    res0.last = (n_res == 2'd1);
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_START;
      pos_q    <= '0;
      fstart_q <= '0;
      flen_q   <= '0;
      ovf_q    <= 1'b0;
    end else if (in_fire) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ovf_q  <= ovf_d;
      if (end_of_data_i) begin
        fstart_q <= '0;
        flen_q   <= '0;
      end else begin
        fstart_q <= fstart_d;
        flen_q   <= flen_d;
      end
    end
  end

  // Queue occupancy after this cycle's push and pop.
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = cnt_d + QCNT_W'(n_res);
    end
    if (out_fire) begin
      cnt_d = cnt_d - QCNT_W'(1);
    end
  end

  // Queue pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  // Queue storage; up to two entries are written per transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_fire && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign field_start_o  = queue_q[rd_ptr_q].start;
  assign field_length_o = queue_q[rd_ptr_q].length;
  assign next_offset_o  = queue_q[rd_ptr_q].next;
  assign run_last_o     = queue_q[rd_ptr_q].last;
  assign overflow_o     = queue_q[rd_ptr_q].ovf;

  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // The position never passes the saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} <= LIMIT)
    else $error("position beyond limit");

  // Overflow is only flagged once the position has saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> ({1'b0, pos_q} == LIMIT))
    else $error("overflow flag without saturated position");

  // The final byte of a buffer returns the parser to its start state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_data_i) |=> (pos_q == '0) && (mode_q == M_START) && !ovf_q)
    else $error("parser not reset after end of data");

endmodule
